@@ sv/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console cell writer: field widths,
// command codes, control characters and geometry defaults.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLS_DEF = 80;
  localparam int ROWS_DEF = 25;

  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 11;
  localparam int POS_W  = 11;
  localparam int WORD_W = 16;
  localparam int ATTR_W = 8;

  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0d;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0a;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

endpackage

@@ sv/tcw_ram.sv @@
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter  int WIDTH = 16,
  parameter  int DEPTH = 2000,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ sv/text_console_cell_writer_top.sv @@
// ----------------------------------------------------------------------------
// text_console_cell_writer_top
// Text console engine over a COLS x ROWS store of 16-bit cells (attribute in
// the high byte, character in the low byte).
//
// Commands are given on in_cmd / in_char_byte / in_cell_index and taken at a
// clock edge where start is high and busy is low. Each command gives exactly
// one result on out_cursor_pos / out_cell_word, shown for one cycle with
// out_valid; the receiver has no way to hold it off.
// Command handling, shaped by the single cell RAM with one write and one
// registered read port:
//   put, carriage return, line feed without scroll, unused command: result in
//   the cycle after the transfer, a new command can follow at once
//   read: result after the registered RAM read and the S_READ state; for an
//   index past the store, in the cycle after the transfer
//   clear: every cell blanked in S_FILL, one cell written per cycle
//   scroll (line feed or wrap on the bottom row): copy of each cell one row up
//   pipelined behind its read, then the bottom row is blanked
// cfg_wr_en / cfg_wr_data load the attribute byte (7 after reset).
// After reset the block runs a clearing pass that zeroes every cell; busy
// stays high during it, attribute writes still go through.
// ----------------------------------------------------------------------------
module text_console_cell_writer_top #(
  parameter int COLS = tcw_pkg::COLS_DEF,
  parameter int ROWS = tcw_pkg::ROWS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [tcw_pkg::CMD_W-1:0]  in_cmd,
  input  logic [tcw_pkg::CHAR_W-1:0] in_char_byte,
  input  logic [tcw_pkg::IDX_W-1:0]  in_cell_index,
  output logic                      out_valid,
  output logic [tcw_pkg::POS_W-1:0]  out_cursor_pos,
  output logic [tcw_pkg::WORD_W-1:0] out_cell_word,
  input  logic                      cfg_wr_en,
  input  logic [tcw_pkg::ATTR_W-1:0] cfg_wr_data
);

  localparam int CELLS = COLS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CLW   = $clog2(COLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = (AW > tcw_pkg::IDX_W) ? AW + 1 : tcw_pkg::IDX_W + 1;

  localparam logic [AW-1:0]  LAST_CELL  = AW'(CELLS - 1);
  localparam logic [AW-1:0]  LAST_BASE  = AW'(CELLS - COLS);
  localparam logic [CLW-1:0] LAST_COL   = CLW'(COLS - 1);
  localparam logic [RW-1:0]  LAST_ROW   = RW'(ROWS - 1);

  typedef enum logic [4:0] {
    S_INIT   = 5'b00001,
    S_IDLE   = 5'b00010,
    S_READ   = 5'b00100,
    S_SCROLL = 5'b01000,
    S_FILL   = 5'b10000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [AW-1:0]               ptr_r, ptr_nxt;
  logic [CLW-1:0]              col_r, col_nxt;
  logic [RW-1:0]               row_r, row_nxt;
  logic [AW-1:0]               cur_addr_r, cur_addr_nxt;
  logic [tcw_pkg::ATTR_W-1:0]  attr_r;
  logic                        out_valid_r, out_valid_nxt;
  logic [tcw_pkg::WORD_W-1:0]  word_r, word_nxt;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [tcw_pkg::WORD_W-1:0]  ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [tcw_pkg::WORD_W-1:0]  ram_rdata;
  logic [tcw_pkg::WORD_W-1:0]  blank;
  logic                        idx_ok;

  assign blank  = {attr_r, 8'h00};
  assign idx_ok = CW'(in_cell_index) < CW'(CELLS);

  tcw_ram #(
    .WIDTH (tcw_pkg::WORD_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_comb begin
    logic newline;
    newline       = 1'b0;
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    cur_addr_nxt  = cur_addr_r;
    out_valid_nxt = 1'b0;
    word_nxt      = word_r;
    ram_we        = 1'b0;
    ram_waddr     = ptr_r;
    ram_wdata     = blank;
    ram_raddr     = AW'(in_cell_index);

    unique case (state_r)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        if (ptr_r == LAST_CELL) begin
          ptr_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end

      S_IDLE: begin
        if (start) begin
          word_nxt = '0;
          unique case (tcw_pkg::cmd_t'(in_cmd))
            tcw_pkg::CMD_PUT: begin
              if (in_char_byte == tcw_pkg::CHAR_CR) begin
                col_nxt       = '0;
                cur_addr_nxt  = cur_addr_r - AW'(col_r);
                out_valid_nxt = 1'b1;
              end else if (in_char_byte == tcw_pkg::CHAR_LF) begin
                newline = 1'b1;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = cur_addr_r;
                ram_wdata = {attr_r, in_char_byte};
                if (col_r == LAST_COL) begin
                  newline = 1'b1;
                end else begin
                  col_nxt       = col_r + CLW'(1);
                  cur_addr_nxt  = cur_addr_r + AW'(1);
                  out_valid_nxt = 1'b1;
                end
              end
            end
            tcw_pkg::CMD_CLEAR: begin
              col_nxt      = '0;
              row_nxt      = '0;
              cur_addr_nxt = '0;
              ptr_nxt      = '0;
              state_nxt    = S_FILL;
            end
            tcw_pkg::CMD_READ: begin
              if (idx_ok) begin
                state_nxt = S_READ;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            tcw_pkg::CMD_NOP: begin
              out_valid_nxt = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase

          if (newline) begin
            col_nxt = '0;
            if (row_r == LAST_ROW) begin
              cur_addr_nxt = LAST_BASE;
              ptr_nxt      = '0;
              state_nxt    = S_SCROLL;
            end else begin
              row_nxt       = row_r + RW'(1);
              cur_addr_nxt  = cur_addr_r - AW'(col_r) + AW'(COLS);
              out_valid_nxt = 1'b1;
            end
          end
        end
      end

      S_READ: begin
        word_nxt      = ram_rdata;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      // read cell ptr+COLS, write the previous read one row up
      S_SCROLL: begin
        ram_raddr = ptr_r + AW'(COLS);
        ram_we    = (ptr_r != '0);
        ram_waddr = ptr_r - AW'(1);
        ram_wdata = ram_rdata;
        if (ptr_r == LAST_BASE) begin
          state_nxt = S_FILL;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end

      S_FILL: begin
        ram_we = 1'b1;
        if (ptr_r == LAST_CELL) begin
          ptr_nxt       = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      ptr_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      cur_addr_r  <= '0;
      attr_r      <= tcw_pkg::ATTR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      cur_addr_r  <= cur_addr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        attr_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_cursor_pos = tcw_pkg::POS_W'(cur_addr_r);
  assign out_cell_word  = word_r;

endmodule

@@ sv/tcw_checker.sv @@
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks for the text console cell writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker #(
  parameter int COLS = tcw_pkg::COLS_DEF,
  parameter int ROWS = tcw_pkg::ROWS_DEF
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic [tcw_pkg::CMD_W-1:0]  in_cmd,
  input logic [tcw_pkg::CHAR_W-1:0] in_char_byte,
  input logic                      out_valid,
  input logic [tcw_pkg::POS_W-1:0]  out_cursor_pos,
  input logic [tcw_pkg::WORD_W-1:0] out_cell_word
);

  localparam int CELLS = COLS * ROWS;

  logic xfer;
  assign xfer = start && !busy;

  // reset starts the clearing pass with no result pending
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> busy && !out_valid)
    else $error("busy or out_valid wrong after reset");

  // carriage return gives its result in the next cycle with an empty cell word
  a_cr_fast: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && in_cmd == tcw_pkg::CMD_PUT && in_char_byte == tcw_pkg::CHAR_CR
    |=> out_valid && out_cell_word == '0)
    else $error("carriage return result missing");

  // unused command reports the unchanged cursor
  a_nop_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && in_cmd == tcw_pkg::CMD_NOP
    |=> out_valid && out_cell_word == '0 && $stable(out_cursor_pos))
    else $error("unused command result wrong");

  // clear walks the whole store before answering
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && in_cmd == tcw_pkg::CMD_CLEAR |=> busy && !out_valid)
    else $error("clear did not hold busy");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CELLS > 2048) || (int'(out_cursor_pos) < CELLS))
    else $error("cursor position out of range");

endmodule

bind text_console_cell_writer_top tcw_checker #(
  .COLS (COLS),
  .ROWS (ROWS)
) u_tcw_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_cmd         (in_cmd),
  .in_char_byte   (in_char_byte),
  .out_valid      (out_valid),
  .out_cursor_pos (out_cursor_pos),
  .out_cell_word  (out_cell_word)
);
